// File: design/sap_pkg.sv
// ----------------------------------------------------------------------------
// sap_pkg
// Shared types, constants and command codes of the stepper ramp profiler.
// ----------------------------------------------------------------------------
package sap_pkg;

  localparam int INTERVAL_BITS    = 16;
  localparam int TICKS_PER_SECOND = 1000;

  localparam int MODE_W    = 2;
  localparam int VAL_W     = 32;
  localparam int SPD_W     = 27;   // signed Q11.16 speed held in state
  localparam int MAX_W     = 26;
  localparam int ACC_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 32;

  localparam int PROD_W = 65;
  localparam int SQ_W   = 64;
  localparam int DIV_W  = 48;
  localparam int CNT_W  = 6;

  localparam int MUL_ITERS       = 32;
  localparam int SQ_ITERS        = 32;
  localparam int RAMP_DIV_ITERS  = DIV_W;
  localparam int IVAL_DVD_W      = $clog2(TICKS_PER_SECOND + 1) + 16;
  localparam int IVAL_DIV_ITERS  = IVAL_DVD_W;

  typedef logic [INTERVAL_BITS-1:0] ival_t;
  localparam ival_t IVAL_MAX = '1;

  // (TICKS_PER_SECOND << 16) left-aligned in the divider word
  localparam logic [DIV_W-1:0] IVAL_DVD_ALIGNED =
    DIV_W'(TICKS_PER_SECOND) << (16 + DIV_W - IVAL_DVD_W);

  // radicand cap 2^62 applies once |d|*accel exceeds 2^45
  localparam logic [PROD_W-1:0] RAD_THRESH = PROD_W'(1) << 45;
  localparam logic [SQ_W-1:0]   RAD_CAP    = SQ_W'(1) << 62;
  localparam logic [SQ_W-1:0]   SQ_BIT0    = SQ_W'(1) << 62;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL     = CFG_IDX_W'(1);

  typedef enum logic [MODE_W-1:0] {
    MODE_TICK     = 2'd0,
    MODE_MOVE_ABS = 2'd1,
    MODE_MOVE_REL = 2'd2,
    MODE_SET_POS  = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_APPLY,
    OP_SPD_ZERO,
    OP_MUL_LOAD,
    OP_MUL_STEP,
    OP_SQ_LOAD_RAD,
    OP_SQ_LOAD_ACC,
    OP_SQ_STEP,
    OP_DIV_LOAD_RAMP,
    OP_DIV_LOAD_IVAL,
    OP_DIV_STEP,
    OP_SET_N_SQ,
    OP_SET_N_DIV,
    OP_SET_IVAL,
    OP_SET_IVAL_MAX,
    OP_OUT_LOAD
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic recompute;  // accepted word needs a speed update
    logic d_zero;     // target equals position
    logic req_gt;     // requested speed above current
    logic req_eq;     // requested speed equals current
    logic spd_zero;   // current speed is zero
  } dp_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_INIT,
    ST_MUL,
    ST_SQ_LOAD,
    ST_SQ1,
    ST_DECIDE,
    ST_SQ2,
    ST_SET_SQ,
    ST_DIV_RAMP,
    ST_SET_DIV,
    ST_IVAL_INIT,
    ST_DIV_IVAL,
    ST_SET_IVAL,
    ST_DONE
  } ctrl_state_e;

endpackage

// File: design/stepper_accel_profile_top.sv
// ----------------------------------------------------------------------------
// stepper_accel_profile_top
// Stepper acceleration ramp profiler: position, target, speed and interval.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o, mode_i, value_i): one word is a
//   1 ms tick, a move absolute, a move relative or a set position.
//   Output channel (out_valid_o / out_stall_i): one result word per input
//   word with step pulse, direction, position, distance to go, speed, running.
//   Config channel (cfg_valid_i / cfg_ready_o): index 0 max speed, index 1
//   acceleration; write only while the block is idle. Ready is always high.
// Sequence:
//   Idle ticks and set position: no speed update, the result is loaded directly.
//   A move onto the current position: speed cleared, interval set to the top.
//   Moves and ticks that step run a speed update on shared sequential units:
//   a shift-add multiply, a root, then a root (from zero speed) or a divide
//   for the ramp unless the requested speed equals the current one, then the
//   interval divide unless the speed is zero.
//   One word is in flight at a time; in_stall_o is high while it is worked on.
// Reset: motion state, config and the output valid flag clear at once; the output data registers are not reset.
// Stall: a finished word sits in the output register while the next input
//   word is taken; a second finished word waits until the first is taken.
// ----------------------------------------------------------------------------
module stepper_accel_profile_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sap_pkg::MODE_W-1:0]        mode_i,
  input  logic signed [sap_pkg::VAL_W-1:0]  value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              step_pulse_o,
  output logic                              direction_o,
  output logic signed [sap_pkg::VAL_W-1:0]  position_o,
  output logic signed [sap_pkg::VAL_W-1:0]  distance_to_go_o,
  output logic signed [sap_pkg::SPD_W-1:0]  speed_now_o,
  output logic                              running_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sap_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [sap_pkg::CFG_DAT_W-1:0]     cfg_data_i
);
  import sap_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // config writes land straight in the datapath registers
  assign cfg_ready_o = 1'b1;

  sap_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sap_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .mode_i           (mode_i),
    .value_i          (value_i),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .step_pulse_o     (step_pulse_o),
    .direction_o      (direction_o),
    .position_o       (position_o),
    .distance_to_go_o (distance_to_go_o),
    .speed_now_o      (speed_now_o),
    .running_o        (running_o)
  );

endmodule

// File: design/sap_ctrl.sv
// ----------------------------------------------------------------------------
// sap_ctrl
// Sequencer: walks the datapath through multiply, root and divide passes.
// ----------------------------------------------------------------------------
module sap_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  sap_pkg::dp_status_t status_i,
  output sap_pkg::dp_cmd_t    cmd_o
);
  import sap_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic              accept;
  logic              out_free;
  logic              cnt_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cnt_last    = (cnt_q == '0);
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = status_i.recompute ? ST_MUL_INIT : ST_DONE;
      end
      ST_MUL_INIT:  state_d = status_i.d_zero ? ST_IVAL_INIT : ST_MUL;
      ST_MUL:       if (cnt_last) state_d = ST_SQ_LOAD;
      ST_SQ_LOAD:   state_d = ST_SQ1;
      ST_SQ1:       if (cnt_last) state_d = ST_DECIDE;
      ST_DECIDE: begin
        if (status_i.req_eq)        state_d = ST_IVAL_INIT;
        else if (status_i.spd_zero) state_d = ST_SQ2;
        else                        state_d = ST_DIV_RAMP;
      end
      ST_SQ2:       if (cnt_last) state_d = ST_SET_SQ;
      ST_SET_SQ:    state_d = ST_IVAL_INIT;
      ST_DIV_RAMP:  if (cnt_last) state_d = ST_SET_DIV;
      ST_SET_DIV:   state_d = ST_IVAL_INIT;
      ST_IVAL_INIT: state_d = status_i.spd_zero ? ST_DONE : ST_DIV_IVAL;
      ST_DIV_IVAL:  if (cnt_last) state_d = ST_SET_IVAL;
      ST_SET_IVAL:  state_d = ST_DONE;
      ST_DONE:      if (out_free) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o.op    = OP_NOP;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (accept) cmd_o.op = OP_APPLY;
      end
      ST_MUL_INIT: begin
        if (status_i.d_zero) begin
          cmd_o.op = OP_SPD_ZERO;
        end else begin
          cmd_o.op = OP_MUL_LOAD;
          cnt_d    = CNT_W'(MUL_ITERS - 1);
        end
      end
      ST_MUL, ST_DIV_RAMP, ST_DIV_IVAL, ST_SQ1, ST_SQ2: begin
        cmd_o.op = (state_q == ST_MUL) ? OP_MUL_STEP :
                   (state_q == ST_SQ1 || state_q == ST_SQ2) ? OP_SQ_STEP : OP_DIV_STEP;
        cnt_d    = cnt_q - CNT_W'(1);
      end
      ST_SQ_LOAD: begin
        cmd_o.op = OP_SQ_LOAD_RAD;
        cnt_d    = CNT_W'(SQ_ITERS - 1);
      end
      ST_DECIDE: begin
        if (!status_i.req_eq) begin
          if (status_i.spd_zero) begin
            cmd_o.op = OP_SQ_LOAD_ACC;
            cnt_d    = CNT_W'(SQ_ITERS - 1);
          end else begin
            cmd_o.op = OP_DIV_LOAD_RAMP;
            cnt_d    = CNT_W'(RAMP_DIV_ITERS - 1);
          end
        end
      end
      ST_SET_SQ:  cmd_o.op = OP_SET_N_SQ;
      ST_SET_DIV: cmd_o.op = OP_SET_N_DIV;
      ST_IVAL_INIT: begin
        if (status_i.spd_zero) begin
          cmd_o.op = OP_SET_IVAL_MAX;
        end else begin
          cmd_o.op = OP_DIV_LOAD_IVAL;
          cnt_d    = CNT_W'(IVAL_DIV_ITERS - 1);
        end
      end
      ST_SET_IVAL: cmd_o.op = OP_SET_IVAL;
      ST_DONE: begin
        if (out_free) begin
          cmd_o.op    = OP_OUT_LOAD;
          out_valid_d = 1'b1;
        end
      end
      default: cmd_o.op = OP_NOP;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");

  a_done_publishes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("finished word not published");
`endif

endmodule

// File: design/sap_datapath.sv
// ----------------------------------------------------------------------------
// sap_datapath
// Motion state, config registers, shift-add multiplier, root and divider.
// ----------------------------------------------------------------------------
module sap_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sap_pkg::dp_cmd_t                cmd_i,
  output sap_pkg::dp_status_t             status_o,
  input  logic [sap_pkg::MODE_W-1:0]      mode_i,
  input  logic signed [sap_pkg::VAL_W-1:0] value_i,
  input  logic                            cfg_we_i,
  input  logic [sap_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [sap_pkg::CFG_DAT_W-1:0]   cfg_data_i,
  output logic                            step_pulse_o,
  output logic                            direction_o,
  output logic signed [sap_pkg::VAL_W-1:0] position_o,
  output logic signed [sap_pkg::VAL_W-1:0] distance_to_go_o,
  output logic signed [sap_pkg::SPD_W-1:0] speed_now_o,
  output logic                            running_o
);
  import sap_pkg::*;

  // motion state and config
  logic signed [VAL_W-1:0] pos_q, pos_d, tgt_q, tgt_d;
  logic signed [SPD_W-1:0] spd_q, spd_d;
  ival_t                   ival_q, ival_d, elap_q, elap_d;
  logic [MAX_W-1:0]        max_q, max_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic                    pulse_q, pulse_d, up_q, up_d;

  // arithmetic scratch
  logic [PROD_W-1:0] mcand_q, mcand_d, prod_q, prod_d;
  logic [ACC_W-1:0]  mplier_q, mplier_d;
  logic [SQ_W-1:0]   sx_q, sx_d, sr_q, sr_d, sbit_q, sbit_d;
  logic [DIV_W-1:0]  dq_q, dq_d;
  logic [SPD_W-1:0]  rem_q, rem_d, dvs_q, dvs_d;

  // output word
  logic                    o_pulse_q, o_dir_q, o_run_q;
  logic signed [VAL_W-1:0] o_pos_q, o_dist_q;
  logic signed [SPD_W-1:0] o_spd_q;

  logic signed [VAL_W:0]   dist33;
  logic [VAL_W:0]          mag33;
  logic                    d_zero;
  ival_t                   elap_inc;
  logic                    step_go;
  logic                    spd_pos, spd_neg;
  logic signed [33:0]      rt34, req34, spd34;
  logic [SPD_W-1:0]        sabs;
  logic [SQ_W-1:0]         rad, sq_t;
  logic                    sq_ge;
  logic [SPD_W:0]          rem_sh, rem_sub;
  logic                    div_ge;
  logic signed [49:0]      n_base, n_mag, n_raw, mx50, n_cl;
  logic signed [VAL_W-1:0] dist_sat;

  assign dist33   = VAL_W'(0) + ({tgt_q[VAL_W-1], tgt_q} - {pos_q[VAL_W-1], pos_q});
  assign mag33    = dist33[VAL_W] ? ((VAL_W+1)'(0) - dist33) : dist33;
  assign d_zero   = (tgt_q == pos_q);
  assign elap_inc = (elap_q == IVAL_MAX) ? elap_q : elap_q + ival_t'(1);
  assign spd_neg  = spd_q[SPD_W-1];
  assign spd_pos  = !spd_neg && (spd_q != '0);
  assign step_go  = (mode_e'(mode_i) == MODE_TICK) && !d_zero && (elap_inc > ival_q);

  assign rt34  = {2'b00, sr_q[31:0]};
  assign req34 = dist33[VAL_W] ? (34'sd0 - rt34) : rt34;
  assign spd34 = 34'(spd_q);
  assign sabs  = spd_neg ? (SPD_W'(0) - spd_q) : spd_q;

  assign status_o.recompute = (mode_e'(mode_i) == MODE_MOVE_ABS) ||
                              (mode_e'(mode_i) == MODE_MOVE_REL) || step_go;
  assign status_o.d_zero    = d_zero;
  assign status_o.req_gt    = req34 > spd34;
  assign status_o.req_eq    = req34 == spd34;
  assign status_o.spd_zero  = (spd_q == '0);

  // radicand 2*|d|*accel in Q32.32, capped
  assign rad = (prod_q > RAD_THRESH) ? RAD_CAP : {prod_q[46:0], 17'b0};

  // one root digit
  assign sq_t  = sr_q + sbit_q;
  assign sq_ge = sx_q >= sq_t;

  // one restoring divide step
  assign rem_sh  = {rem_q, dq_q[DIV_W-1]};
  assign div_ge  = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  // ramped speed and clamp
  assign n_base = (cmd_i.op == OP_SET_N_SQ) ? 50'sd0 : 50'(spd_q);
  assign n_mag  = (cmd_i.op == OP_SET_N_SQ) ? 50'(sr_q[31:0]) : 50'(dq_q);
  assign n_raw  = up_q ? (n_base + n_mag) : (n_base - n_mag);
  assign mx50   = 50'(max_q);
  always_comb begin
    n_cl = n_raw;
    if (up_q && n_raw > mx50)                  n_cl = mx50;
    if (!up_q && n_raw < (50'sd0 - mx50))      n_cl = 50'sd0 - mx50;
  end

  always_comb begin
    if (dist33[VAL_W] != dist33[VAL_W-1]) begin
      dist_sat = dist33[VAL_W] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
    end else begin
      dist_sat = dist33[VAL_W-1:0];
    end
  end

  // config writes
  always_comb begin
    max_d = max_q;
    acc_d = acc_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_SPEED: max_d = cfg_data_i[MAX_W-1:0];
        CFG_ACCEL:     acc_d = cfg_data_i[ACC_W-1:0];
        default:       max_d = max_q;
      endcase
    end
  end

  always_comb begin
    pos_d    = pos_q;
    tgt_d    = tgt_q;
    spd_d    = spd_q;
    ival_d   = ival_q;
    elap_d   = elap_q;
    pulse_d  = pulse_q;
    up_d     = up_q;
    mcand_d  = mcand_q;
    prod_d   = prod_q;
    mplier_d = mplier_q;
    sx_d     = sx_q;
    sr_d     = sr_q;
    sbit_d   = sbit_q;
    dq_d     = dq_q;
    rem_d    = rem_q;
    dvs_d    = dvs_q;
    case (cmd_i.op)
      OP_APPLY: begin
        pulse_d = 1'b0;
        case (mode_e'(mode_i))
          MODE_TICK: begin
            if (step_go) begin
              if (spd_pos)      pos_d = pos_q + VAL_W'(1);
              else if (spd_neg) pos_d = pos_q - VAL_W'(1);
              pulse_d = 1'b1;
              elap_d  = '0;
            end else begin
              elap_d  = elap_inc;
            end
          end
          MODE_MOVE_ABS: tgt_d = value_i;
          MODE_MOVE_REL: tgt_d = pos_q + value_i;
          MODE_SET_POS:  pos_d = value_i;
          default:       pulse_d = 1'b0;
        endcase
      end
      OP_SPD_ZERO: spd_d = '0;
      OP_MUL_LOAD: begin
        mcand_d  = PROD_W'(mag33);
        mplier_d = acc_q;
        prod_d   = '0;
      end
      OP_MUL_STEP: begin
        if (mplier_q[0]) prod_d = prod_q + mcand_q;
        mcand_d  = {mcand_q[PROD_W-2:0], 1'b0};
        mplier_d = {1'b0, mplier_q[ACC_W-1:1]};
      end
      OP_SQ_LOAD_RAD: begin
        sx_d   = rad;
        sr_d   = '0;
        sbit_d = SQ_BIT0;
      end
      OP_SQ_LOAD_ACC: begin
        up_d   = status_o.req_gt;
        sx_d   = SQ_W'({acc_q, 17'b0});
        sr_d   = '0;
        sbit_d = SQ_BIT0;
      end
      OP_SQ_STEP: begin
        if (sq_ge) begin
          sx_d = sx_q - sq_t;
          sr_d = (sr_q >> 1) + sbit_q;
        end else begin
          sr_d = sr_q >> 1;
        end
        sbit_d = sbit_q >> 2;
      end
      OP_DIV_LOAD_RAMP: begin
        up_d  = status_o.req_gt;
        dq_d  = {acc_q, 16'b0};
        rem_d = '0;
        dvs_d = sabs;
      end
      OP_DIV_LOAD_IVAL: begin
        dq_d  = IVAL_DVD_ALIGNED;
        rem_d = '0;
        dvs_d = sabs;
      end
      OP_DIV_STEP: begin
        rem_d = div_ge ? rem_sub[SPD_W-1:0] : rem_sh[SPD_W-1:0];
        dq_d  = {dq_q[DIV_W-2:0], div_ge};
      end
      OP_SET_N_SQ, OP_SET_N_DIV: spd_d = n_cl[SPD_W-1:0];
      OP_SET_IVAL: begin
        ival_d = (dq_q > DIV_W'(IVAL_MAX)) ? IVAL_MAX : dq_q[INTERVAL_BITS-1:0];
      end
      OP_SET_IVAL_MAX: ival_d = IVAL_MAX;
      default: pulse_d = pulse_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      tgt_q   <= '0;
      spd_q   <= '0;
      ival_q  <= '0;
      elap_q  <= '0;
      max_q   <= '0;
      acc_q   <= '0;
      pulse_q <= 1'b0;
      up_q    <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      tgt_q   <= tgt_d;
      spd_q   <= spd_d;
      ival_q  <= ival_d;
      elap_q  <= elap_d;
      max_q   <= max_d;
      acc_q   <= acc_d;
      pulse_q <= pulse_d;
      up_q    <= up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    prod_q   <= prod_d;
    mplier_q <= mplier_d;
    sx_q     <= sx_d;
    sr_q     <= sr_d;
    sbit_q   <= sbit_d;
    dq_q     <= dq_d;
    rem_q    <= rem_d;
    dvs_q    <= dvs_d;
    if (cmd_i.op == OP_OUT_LOAD) begin
      o_pulse_q <= pulse_q;
      o_dir_q   <= spd_pos;
      o_pos_q   <= pos_q;
      o_dist_q  <= dist_sat;
      o_spd_q   <= spd_q;
      o_run_q   <= !d_zero;
    end
  end

  assign step_pulse_o     = o_pulse_q;
  assign direction_o      = o_dir_q;
  assign position_o       = o_pos_q;
  assign distance_to_go_o = o_dist_q;
  assign speed_now_o      = o_spd_q;
  assign running_o        = o_run_q;

`ifndef SYNTHESIS
  a_speed_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (spd_q <= $signed(SPD_W'((1 << MAX_W) - 1))) &&
    (spd_q >= $signed(SPD_W'(0) - SPD_W'((1 << MAX_W) - 1))))
    else $error("speed outside clamp range");
`endif

endmodule

// File: bench/tb_stepper_accel_profile_top.sv
// ----------------------------------------------------------------------------
// tb_stepper_accel_profile_top
// Self-checking bench for the stepper acceleration ramp profiler.
// A built-in motion predictor follows every accepted word. Each result is
// checked field by field against the oldest prediction, with random idling
// on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stepper_accel_profile_top;
  import sap_pkg::*;

  localparam int          CYCLE_LIMIT = 2_000_000;
  localparam int          DRAIN_WAIT  = 200;   // above the longest speed update
  localparam logic [15:0] IVAL_TOP    = '1;

  typedef struct packed {
    logic        pulse;
    logic        dir;
    logic [31:0] pos;
    logic [31:0] togo;
    logic [26:0] spd;
    logic        run;
  } motion_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [MODE_W-1:0]    mode_i;
  logic signed [31:0]   value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 step_pulse_o;
  logic                 direction_o;
  logic signed [31:0]   position_o;
  logic signed [31:0]   distance_to_go_o;
  logic signed [26:0]   speed_now_o;
  logic                 running_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DAT_W-1:0] cfg_data_i;

  stepper_accel_profile_top i_dut (.*);

  // predictor state
  logic [25:0] max_spd;
  logic [31:0] accel;
  logic [31:0] cur_pos;
  logic [31:0] tgt_pos;
  logic [31:0] spd_reg;
  logic [15:0] ival;
  logic [15:0] elapsed;

  motion_result_t motion_q[$];
  int  mismatches    = 0;
  int  words_sent    = 0;
  int  words_checked = 0;
  int  steps_seen    = 0;
  int  cycles        = 0;
  bit  idle_on;   // random gaps and stalls enabled

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // cycle limit; trips only on a hang
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---- predictor ----------------------------------------------------------
  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // next speed on the ramp towards sqrt(2*|d|*a), clamped to max
  function automatic longint ramp_speed();
    longint          d, cur, lim, req, n, cur_mag;
    longint unsigned mag, rad, a;
    d   = longint'($signed(tgt_pos)) - longint'($signed(cur_pos));
    cur = longint'($signed(spd_reg));
    lim = longint'(max_spd);
    a   = longint'(accel);
    if (d == 0) return 0;
    mag = (d > 0) ? d : -d;
    if (a == 0) rad = 0;
    else if (mag > (64'd1 << 45) / a) rad = 64'd1 << 62;
    else rad = (mag * a) << 17;
    req = longint'(root64(rad));
    if (d < 0) req = -req;
    cur_mag = (cur < 0) ? -cur : cur;
    if (req > cur) begin
      if (cur == 0) n = longint'(root64(a << 17));
      else n = cur + longint'((a << 16) / longint'(cur_mag));
      if (n > lim) n = lim;
    end else if (req < cur) begin
      if (cur == 0) n = -longint'(root64(a << 17));
      else n = cur - longint'((a << 16) / longint'(cur_mag));
      if (n < -lim) n = -lim;
    end else begin
      n = req;
    end
    return n;
  endfunction

  function automatic void update_speed();
    longint          n;
    longint unsigned s, q;
    n = ramp_speed();
    s = (n < 0) ? -n : n;
    spd_reg = n[31:0];
    if (s == 0) begin
      ival = IVAL_TOP;
    end else begin
      q = (longint'(TICKS_PER_SECOND) << 16) / s;
      ival = (q > IVAL_TOP) ? IVAL_TOP : q[15:0];
    end
  endfunction

  function automatic motion_result_t predict_motion(mode_e m, logic [31:0] v);
    motion_result_t r;
    longint         d;
    r = '0;
    case (m)
      MODE_TICK: begin
        if (elapsed != IVAL_TOP) elapsed = elapsed + 1;
        if (tgt_pos != cur_pos && elapsed > ival) begin
          if ($signed(spd_reg) > 0) cur_pos = cur_pos + 1;
          else if ($signed(spd_reg) < 0) cur_pos = cur_pos - 1;
          r.pulse = 1'b1;
          elapsed = '0;
          update_speed();
        end
      end
      MODE_MOVE_ABS: begin
        tgt_pos = v;
        update_speed();
      end
      MODE_MOVE_REL: begin
        tgt_pos = cur_pos + v;
        update_speed();
      end
      default: cur_pos = v;
    endcase
    d = longint'($signed(tgt_pos)) - longint'($signed(cur_pos));
    if (d > 64'sh7FFF_FFFF) d = 64'sh7FFF_FFFF;
    if (d < -64'sh8000_0000) d = -64'sh8000_0000;
    r.dir  = $signed(spd_reg) > 0;
    r.pos  = cur_pos;
    r.togo = d[31:0];
    r.spd  = spd_reg[26:0];
    r.run  = tgt_pos != cur_pos;
    return r;
  endfunction

  // ---- channel drivers ----------------------------------------------------
  task automatic send_word(mode_e m, logic [31:0] v);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i     <= m;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    motion_q.push_back(predict_motion(m, v));
    words_sent++;
  endtask

  // hold off the sender until every outstanding result is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (motion_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_MAX_SPEED) max_spd = data[25:0];
    else accel = data;
  endtask

  task automatic set_profile(logic [31:0] mx, logic [31:0] acc);
    drain();
    write_reg(CFG_MAX_SPEED, mx);
    write_reg(CFG_ACCEL, acc);
    cfg_valid_i <= 1'b0;
  endtask

  // receiver stall bursts
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
    end
  end

  // ---- result checker -----------------------------------------------------
  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
    if (exp !== act) begin
      $error("%s: expected %0h, got %0h", name, exp, act);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    motion_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (motion_q.size() == 0) begin
        $error("result word with nothing outstanding");
        mismatches++;
      end else begin
        e = motion_q.pop_front();
        check_field("step_pulse", 32'(e.pulse), 32'(step_pulse_o));
        check_field("direction", 32'(e.dir), 32'(direction_o));
        check_field("position", e.pos, position_o);
        check_field("distance_to_go", e.togo, distance_to_go_o);
        check_field("speed_now", {5'b0, e.spd}, {5'b0, speed_now_o});
        check_field("running", 32'(e.run), 32'(running_o));
        words_checked++;
        if (e.pulse) steps_seen++;
      end
    end
  end

  // ---- tests --------------------------------------------------------------
  // straight after reset the interval is 0, so a tick steps at zero speed
  task automatic test_zero_speed_step();
    send_word(MODE_SET_POS, 32'd7);
    send_word(MODE_TICK, 32'hFFFF_FFFF);
    send_word(MODE_TICK, 32'd0);
  endtask

  task automatic test_command_extremes();
    set_profile(32'd65536000, 32'hFFFF_FFFF);
    send_word(MODE_SET_POS, 32'h8000_0000);
    send_word(MODE_MOVE_ABS, 32'h7FFF_FFFF);  // distance saturates high
    send_word(MODE_TICK, 32'd0);
    send_word(MODE_TICK, 32'd0);
    send_word(MODE_MOVE_REL, 32'h8000_0000);  // target wraps
    send_word(MODE_SET_POS, 32'h7FFF_FFFF);
    send_word(MODE_MOVE_ABS, 32'h8000_0000);  // distance saturates low
    send_word(MODE_TICK, 32'd0);
    send_word(MODE_TICK, 32'd0);
    send_word(MODE_MOVE_ABS, 32'h8000_0003);  // target for the set position and zero move below: speed to zero
    send_word(MODE_SET_POS, 32'h8000_0003);
    send_word(MODE_MOVE_REL, 32'd0);
  endtask

  // speed kept across set position is cleared by a move onto the new position
  task automatic test_position_wrap();
    set_profile(32'd1000 << 16, 32'd100000 << 16);
    send_word(MODE_SET_POS, 32'd0);
    send_word(MODE_MOVE_ABS, 32'd50);
    send_word(MODE_SET_POS, 32'h7FFF_FFFF);
    send_word(MODE_MOVE_ABS, 32'h7FFF_FFFF);
    send_word(MODE_SET_POS, 32'h7FFF_FFFE);
    for (int i = 0; i < 6; i++) send_word(MODE_TICK, 32'd0);
  endtask

  // zero acceleration gives zero speed: the interval pins at the top and
  // idle ticks bring no step until a new speed is set
  task automatic test_saturated_interval();
    bit keep;
    keep = idle_on;
    idle_on = 0;
    set_profile(32'd1000 << 16, 32'd0);
    send_word(MODE_SET_POS, 32'd0);
    send_word(MODE_MOVE_ABS, 32'd5);
    for (int i = 0; i < 40; i++) send_word(MODE_TICK, 32'd0);
    set_profile(32'd1000 << 16, 32'd100000 << 16);
    send_word(MODE_MOVE_ABS, 32'd9);
    for (int i = 0; i < 4; i++) send_word(MODE_TICK, 32'd0);
    idle_on = keep;
  endtask

  task automatic test_random_motion(int count, logic [31:0] mx, logic [31:0] acc);
    int r;
    set_profile(mx, acc);
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 68) send_word(MODE_TICK, $urandom);
      else if (r < 80)
        send_word(MODE_MOVE_ABS, cur_pos + $urandom_range(0, 80) - 40);
      else if (r < 88) send_word(MODE_MOVE_REL, $urandom_range(0, 60) - 30);
      else if (r < 93) send_word(MODE_SET_POS, cur_pos + $urandom_range(0, 6) - 3);
      else send_word(mode_e'($urandom_range(0, 3)), $urandom);
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    mode_i      = MODE_TICK;
    value_i     = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_MAX_SPEED;
    cfg_data_i  = '0;
    idle_on     = 1;
    max_spd = '0; accel = '0; cur_pos = '0; tgt_pos = '0;
    spd_reg = '0; ival = '0; elapsed = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_speed_step();
    test_command_extremes();
    test_position_wrap();
    test_saturated_interval();
    test_random_motion(80, 32'd1000 << 16, 32'd5000 << 16);
    test_random_motion(80, 32'd65536000, 32'hFFFF_FFFF);
    test_random_motion(50, 32'd0, $urandom);
    test_random_motion(50, $urandom_range(1, 65536000), $urandom_range(1 << 16, 1 << 28));
    idle_on = 0;   // closing stretch at full rate
    test_random_motion(70, 32'd2000 << 16, 32'd40000 << 16);

    drain();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("covered: %0d words sent, %0d results checked, %0d step pulses",
             words_sent, words_checked, steps_seen);
    $display("ramp profiles from zero to full speed and acceleration, with stalls");
    if (mismatches == 0 && motion_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
